// ----- sv/dhhm_pkg.sv -----
// Shared widths, codes, reset values and control types for the dual hysteresis
// health monitor. No dependencies.
package dhhm_pkg;

  localparam int SAMPLE_W           = 16;
  localparam int TIME_W             = 48;
  localparam int REG_W              = 15;
  localparam int COUNT_WIDTH        = 16;
  localparam int SEVERITY_FRAC_BITS = 8;
  localparam int SEV_W              = SEVERITY_FRAC_BITS + 1;
  localparam int STEP_W             = $clog2(SEVERITY_FRAC_BITS);
  localparam int HEALTH_W           = 2;
  localparam int CFG_IDX_W          = 3;
  localparam int CMP_W              = SAMPLE_W + 1;

  localparam logic [STEP_W-1:0]      LAST_STEP = STEP_W'(SEVERITY_FRAC_BITS - 1);
  localparam logic [SEV_W-1:0]       SEV_FULL  = SEV_W'(1) << SEVERITY_FRAC_BITS;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  localparam logic [HEALTH_W-1:0] HEALTH_OK   = 2'd0;
  localparam logic [HEALTH_W-1:0] HEALTH_WARN = 2'd1;
  localparam logic [HEALTH_W-1:0] HEALTH_CRIT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_VIB_WARN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VIB_CRIT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VIB_HYST  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_WARN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_CRIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_HYST = 3'd5;

  localparam logic [REG_W-1:0] RST_VIB_WARN  = 15'd256;
  localparam logic [REG_W-1:0] RST_VIB_CRIT  = 15'd512;
  localparam logic [REG_W-1:0] RST_VIB_HYST  = 15'd26;
  localparam logic [REG_W-1:0] RST_TEMP_WARN = 15'd960;
  localparam logic [REG_W-1:0] RST_TEMP_CRIT = 15'd1280;
  localparam logic [REG_W-1:0] RST_TEMP_HYST = 15'd32;

  localparam logic SEL_VIB  = 1'b0;
  localparam logic SEL_TEMP = 1'b1;

  typedef struct packed {
    logic load;
    logic div_init;
    logic div_step;
    logic sev_store;
    logic out_load;
    logic sel;
  } cmd_t;

  typedef struct packed {
    logic [HEALTH_W-1:0]    health;
    logic                   vib_flag;
    logic                   temp_flag;
    logic [SEV_W-1:0]       vib_sev;
    logic [SEV_W-1:0]       temp_sev;
    logic [COUNT_WIDTH-1:0] alert_total;
    logic [TIME_W-1:0]      time_echo;
  } res_t;

endpackage

// ----- sv/dhhm_if.sv -----
// Valid/ready channel interfaces for sample words and result words.
// Depends on dhhm_pkg.
interface dhhm_in_if;
  import dhhm_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] vib_sample;
  logic signed [SAMPLE_W-1:0] temp_sample;
  logic [TIME_W-1:0]          sample_time;

  modport source(output valid, output vib_sample, output temp_sample, output sample_time,
                 input ready);
  modport sink(input valid, input vib_sample, input temp_sample, input sample_time,
               output ready);
endinterface

interface dhhm_out_if;
  import dhhm_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [HEALTH_W-1:0]    health;
  logic                   vib_flag;
  logic                   temp_flag;
  logic [SEV_W-1:0]       vib_sev;
  logic [SEV_W-1:0]       temp_sev;
  logic [COUNT_WIDTH-1:0] alert_total;
  logic [TIME_W-1:0]      time_echo;

  modport source(output valid, output health, output vib_flag, output temp_flag,
                 output vib_sev, output temp_sev, output alert_total,
                 output time_echo, input ready);
  modport sink(input valid, input health, input vib_flag, input temp_flag,
               input vib_sev, input temp_sev, input alert_total,
               input time_echo, output ready);
endinterface

// ----- sv/dual_hysteresis_health_monitor.sv -----
// Dual hysteresis health monitor, top level: wires the sequencer and datapath
// to the channels and the configuration port. Depends on dhhm_pkg, dhhm_if,
// dhhm_ctrl, dhhm_dp.
//
// One result word per sample word. The accepting cycle updates the flags, alert
// counter and health; then for each sensor in turn a setup state, eight restoring
// steps of the shared severity divider and a store state run, and a final state
// loads the output register. The next sample is accepted in the cycle after that
// register is loaded, even while the previous result still waits to be taken; a
// result that is not taken stalls the word behind it in its final state.
// Configuration writes take effect at the clock edge that sees the write enable
// and are meant for idle periods only.
module dual_hysteresis_health_monitor (
  input  logic                             clk,
  input  logic                             rst_n,
  dhhm_in_if.sink                          in_ch,
  dhhm_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [dhhm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dhhm_pkg::REG_W-1:0]       cfg_wdata
);
  import dhhm_pkg::*;

  cmd_t cmd;
  res_t res;
  logic in_ready;
  logic out_valid;

  dhhm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_ready (out_ch.ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  dhhm_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .vib_sample  (in_ch.vib_sample),
    .temp_sample (in_ch.temp_sample),
    .sample_time (in_ch.sample_time),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .res         (res)
  );

  assign in_ch.ready        = in_ready;
  assign out_ch.valid       = out_valid;
  assign out_ch.health      = res.health;
  assign out_ch.vib_flag    = res.vib_flag;
  assign out_ch.temp_flag   = res.temp_flag;
  assign out_ch.vib_sev     = res.vib_sev;
  assign out_ch.temp_sev    = res.temp_sev;
  assign out_ch.alert_total = res.alert_total;
  assign out_ch.time_echo   = res.time_echo;

endmodule

// ----- sv/dhhm_ctrl.sv -----
// Sequencer for the health monitor: accepts a word, runs the shared divider for
// both sensors, then hands the result to the output register. Depends on dhhm_pkg.
module dhhm_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           out_ready,
  output logic           out_valid,
  output dhhm_pkg::cmd_t cmd
);
  import dhhm_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_INIT  = 3'd1;
  localparam logic [2:0] S_STEP  = 3'd2;
  localparam logic [2:0] S_STORE = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              sel_r, sel_nxt;
  logic              out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      sel_r       <= SEL_VIB;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    sel_nxt       = sel_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.sel       = sel_r;
    in_ready      = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          sel_nxt   = SEL_VIB;
          state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        cmd.div_init = 1'b1;
        step_nxt     = '0;
        state_nxt    = S_STEP;
      end
      S_STEP: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + STEP_W'(1);
        if (step_r == LAST_STEP) begin
          state_nxt = S_STORE;
        end
      end
      S_STORE: begin
        cmd.sev_store = 1'b1;
        if (sel_r == SEL_VIB) begin
          sel_nxt   = SEL_TEMP;
          state_nxt = S_INIT;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// ----- sv/dhhm_dp.sv -----
// Datapath of the health monitor: configuration registers, hysteresis flags,
// alert counter, shared restoring divider and output register. Depends on dhhm_pkg.
module dhhm_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  dhhm_pkg::cmd_t                       cmd,
  input  logic signed [dhhm_pkg::SAMPLE_W-1:0] vib_sample,
  input  logic signed [dhhm_pkg::SAMPLE_W-1:0] temp_sample,
  input  logic [dhhm_pkg::TIME_W-1:0]          sample_time,
  input  logic                                 cfg_we,
  input  logic [dhhm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dhhm_pkg::REG_W-1:0]           cfg_wdata,
  output dhhm_pkg::res_t                       res
);
  import dhhm_pkg::*;

  logic [REG_W-1:0] vib_warn_r, vib_crit_r, vib_hyst_r;
  logic [REG_W-1:0] temp_warn_r, temp_crit_r, temp_hyst_r;

  logic                   vib_alarm_r, vib_alarm_nxt;
  logic                   temp_alarm_r, temp_alarm_nxt;
  logic [COUNT_WIDTH-1:0] count_r, count_nxt;

  logic signed [SAMPLE_W-1:0] vib_r, temp_r;
  logic [TIME_W-1:0]          time_r;
  logic [HEALTH_W-1:0]        health_r, health_nxt;
  logic [SEV_W-1:0]           vib_sev_r, temp_sev_r;
  logic [REG_W-1:0]           rem_r, rem_nxt;
  logic [SEVERITY_FRAC_BITS-1:0] quo_r, quo_nxt;
  res_t                       res_r;

  logic signed [CMP_W-1:0] vs, ts, v_warn, t_warn, v_low, t_low, v_crit, t_crit;
  logic                    v_rise, t_rise;
  logic [COUNT_WIDTH:0]    count_sum;

  logic signed [SAMPLE_W-1:0] div_s;
  logic signed [CMP_W-1:0]    div_s17, div_crit17;
  logic [REG_W-1:0]           div_crit;
  logic [REG_W:0]             trial;
  logic [SEV_W-1:0]           sev_val;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vib_warn_r  <= RST_VIB_WARN;
      vib_crit_r  <= RST_VIB_CRIT;
      vib_hyst_r  <= RST_VIB_HYST;
      temp_warn_r <= RST_TEMP_WARN;
      temp_crit_r <= RST_TEMP_CRIT;
      temp_hyst_r <= RST_TEMP_HYST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VIB_WARN:  vib_warn_r  <= cfg_wdata;
        REG_VIB_CRIT:  vib_crit_r  <= cfg_wdata;
        REG_VIB_HYST:  vib_hyst_r  <= cfg_wdata;
        REG_TEMP_WARN: temp_warn_r <= cfg_wdata;
        REG_TEMP_CRIT: temp_crit_r <= cfg_wdata;
        REG_TEMP_HYST: temp_hyst_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    vs     = CMP_W'(vib_sample);
    ts     = CMP_W'(temp_sample);
    v_warn = $signed({2'b00, vib_warn_r});
    t_warn = $signed({2'b00, temp_warn_r});
    v_low  = v_warn - $signed({2'b00, vib_hyst_r});
    t_low  = t_warn - $signed({2'b00, temp_hyst_r});
    v_crit = $signed({2'b00, vib_crit_r});
    t_crit = $signed({2'b00, temp_crit_r});

    v_rise         = !vib_alarm_r && (vs >= v_warn);
    t_rise         = !temp_alarm_r && (ts >= t_warn);
    vib_alarm_nxt  = vib_alarm_r ? !(vs < v_low) : (vs >= v_warn);
    temp_alarm_nxt = temp_alarm_r ? !(ts < t_low) : (ts >= t_warn);

    count_sum = {1'b0, count_r} + (COUNT_WIDTH + 1)'(v_rise) + (COUNT_WIDTH + 1)'(t_rise);
    count_nxt = count_sum[COUNT_WIDTH] ? COUNT_MAX : count_sum[COUNT_WIDTH-1:0];

    if ((vs >= v_crit) || (ts >= t_crit)) begin
      health_nxt = HEALTH_CRIT;
    end else if (vib_alarm_nxt || temp_alarm_nxt) begin
      health_nxt = HEALTH_WARN;
    end else begin
      health_nxt = HEALTH_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vib_alarm_r  <= 1'b0;
      temp_alarm_r <= 1'b0;
      count_r      <= '0;
    end else if (cmd.load) begin
      vib_alarm_r  <= vib_alarm_nxt;
      temp_alarm_r <= temp_alarm_nxt;
      count_r      <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      vib_r    <= vib_sample;
      temp_r   <= temp_sample;
      time_r   <= sample_time;
      health_r <= health_nxt;
    end
  end

  always_comb begin
    div_s      = (cmd.sel == SEL_TEMP) ? temp_r : vib_r;
    div_crit   = (cmd.sel == SEL_TEMP) ? temp_crit_r : vib_crit_r;
    div_s17    = CMP_W'(div_s);
    div_crit17 = $signed({2'b00, div_crit});
    trial      = {rem_r, 1'b0};
    rem_nxt    = rem_r;
    quo_nxt    = quo_r;
    if (cmd.div_init) begin
      rem_nxt = div_s[REG_W-1:0];
      quo_nxt = '0;
    end else if (cmd.div_step) begin
      if (trial >= {1'b0, div_crit}) begin
        rem_nxt = REG_W'(trial - {1'b0, div_crit});
        quo_nxt = {quo_r[SEVERITY_FRAC_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = trial[REG_W-1:0];
        quo_nxt = {quo_r[SEVERITY_FRAC_BITS-2:0], 1'b0};
      end
    end
    if (div_s17 >= div_crit17) begin
      sev_val = SEV_FULL;
    end else if (div_s17 <= CMP_W'(0)) begin
      sev_val = '0;
    end else begin
      sev_val = {1'b0, quo_r};
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (cmd.sev_store) begin
      if (cmd.sel == SEL_TEMP) begin
        temp_sev_r <= sev_val;
      end else begin
        vib_sev_r <= sev_val;
      end
    end
    if (cmd.out_load) begin
      res_r.health      <= health_r;
      res_r.vib_flag    <= vib_alarm_r;
      res_r.temp_flag   <= temp_alarm_r;
      res_r.vib_sev     <= vib_sev_r;
      res_r.temp_sev    <= temp_sev_r;
      res_r.alert_total <= count_r;
      res_r.time_echo   <= time_r;
    end
  end

  assign res = res_r;

endmodule

// ----- sv/dhhm_chk.sv -----
// Port-level assertions for the health monitor and the bind that attaches them
// to the top level. Depends on dhhm_pkg and dual_hysteresis_health_monitor.
module dhhm_chk (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic [dhhm_pkg::HEALTH_W-1:0]        health,
  input logic                                 vib_flag,
  input logic                                 temp_flag,
  input logic [dhhm_pkg::SEV_W-1:0]           vib_sev,
  input logic [dhhm_pkg::SEV_W-1:0]           temp_sev,
  input logic [dhhm_pkg::TIME_W-1:0]          time_echo
);
  import dhhm_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(time_echo) && $stable(health))
    else $error("result word changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word accepted while one is in work");

  a_sev_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (vib_sev <= SEV_FULL) && (temp_sev <= SEV_FULL))
    else $error("severity above full scale");

  a_health_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (health == HEALTH_OK) |-> !vib_flag && !temp_flag)
    else $error("normal health with a flag set");

endmodule

bind dual_hysteresis_health_monitor dhhm_chk u_dhhm_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .health    (out_ch.health),
  .vib_flag  (out_ch.vib_flag),
  .temp_flag (out_ch.temp_flag),
  .vib_sev   (out_ch.vib_sev),
  .temp_sev  (out_ch.temp_sev),
  .time_echo (out_ch.time_echo)
);

// ----- sim/dhhm_health_checker.sv -----
// Checker for the dual hysteresis health monitor: watches the sample, result and
// configuration ports, predicts every result word and compares it field by field.
// Depends on dhhm_pkg and dhhm_if.
module dhhm_health_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  dhhm_in_if                             in_mon,
  dhhm_out_if                            out_mon,
  input  logic                           cfg_we,
  input  logic [dhhm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dhhm_pkg::REG_W-1:0]     cfg_wdata,
  output int                             mismatches,
  output int                             outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import dhhm_pkg::*;

  logic [REG_W-1:0]       vib_warn, vib_crit, vib_hyst;
  logic [REG_W-1:0]       temp_warn, temp_crit, temp_hyst;
  logic                   vib_alarm, temp_alarm;
  logic [COUNT_WIDTH-1:0] alert_tally;
  res_t                   health_due[$];
  int                     err_count = 0;

  task automatic note_mismatch(input string msg);
    err_count++;
    $display("%0t ns mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input longint got, input longint want);
    if (got != want) note_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
  endtask

  function automatic logic [SEV_W-1:0] scale_severity(int s, int crit);
    if (s >= crit) return SEV_FULL;
    if (s <= 0) return '0;
    return SEV_W'((s << SEVERITY_FRAC_BITS) / crit);
  endfunction

  function automatic logic next_flag(logic flag, int s, int warn, int hyst);
    if (!flag) return s >= warn;
    return !(s < warn - hyst);
  endfunction

  task automatic bump_alerts();
    if (alert_tally != COUNT_MAX) alert_tally++;
  endtask

  task automatic predict_health(input logic signed [SAMPLE_W-1:0] vib_in,
                                input logic signed [SAMPLE_W-1:0] temp_in,
                                input logic [TIME_W-1:0] stamp, output res_t r);
    int   v, t;
    logic nv, nt;
    v  = vib_in;
    t  = temp_in;
    nv = next_flag(vib_alarm, v, int'(vib_warn), int'(vib_hyst));
    if (nv && !vib_alarm) bump_alerts();
    vib_alarm = nv;
    nt = next_flag(temp_alarm, t, int'(temp_warn), int'(temp_hyst));
    if (nt && !temp_alarm) bump_alerts();
    temp_alarm = nt;
    if (v >= int'(vib_crit) || t >= int'(temp_crit)) r.health = HEALTH_CRIT;
    else if (vib_alarm || temp_alarm) r.health = HEALTH_WARN;
    else r.health = HEALTH_OK;
    r.vib_flag    = vib_alarm;
    r.temp_flag   = temp_alarm;
    r.vib_sev     = scale_severity(v, int'(vib_crit));
    r.temp_sev    = scale_severity(t, int'(temp_crit));
    r.alert_total = alert_tally;
    r.time_echo   = stamp;
  endtask

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      vib_warn    = RST_VIB_WARN;
      vib_crit    = RST_VIB_CRIT;
      vib_hyst    = RST_VIB_HYST;
      temp_warn   = RST_TEMP_WARN;
      temp_crit   = RST_TEMP_CRIT;
      temp_hyst   = RST_TEMP_HYST;
      vib_alarm   = 1'b0;
      temp_alarm  = 1'b0;
      alert_tally = '0;
      health_due.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (health_due.size() == 0) begin
          note_mismatch("result word with nothing awaited");
        end else begin
          want = health_due.pop_front();
          check_field("health", out_mon.health, want.health);
          check_field("vib_flag", out_mon.vib_flag, want.vib_flag);
          check_field("temp_flag", out_mon.temp_flag, want.temp_flag);
          check_field("vib_sev", out_mon.vib_sev, want.vib_sev);
          check_field("temp_sev", out_mon.temp_sev, want.temp_sev);
          check_field("alert_total", out_mon.alert_total, want.alert_total);
          check_field("time_echo", out_mon.time_echo, want.time_echo);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        predict_health(in_mon.vib_sample, in_mon.temp_sample, in_mon.sample_time, want);
        health_due.push_back(want);
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_VIB_WARN:  vib_warn  = cfg_wdata;
          REG_VIB_CRIT:  vib_crit  = cfg_wdata;
          REG_VIB_HYST:  vib_hyst  = cfg_wdata;
          REG_TEMP_WARN: temp_warn = cfg_wdata;
          REG_TEMP_CRIT: temp_crit = cfg_wdata;
          REG_TEMP_HYST: temp_hyst = cfg_wdata;
          default: ;
        endcase
      end
    end
    outstanding <= health_due.size();
    mismatches  <= err_count;
  end

endmodule

// ----- sim/dual_hysteresis_health_monitor_test.sv -----
// Testbench top for the dual hysteresis health monitor: clock, reset, sample words,
// result back-pressure and register settings; verdict from dhhm_health_checker.
// Depends on dhhm_pkg, dhhm_if, the block and the checker.
module dual_hysteresis_health_monitor_test;
  timeunit 1ns;
  timeprecision 1ps;
  import dhhm_pkg::*;

  localparam int LIMIT    = 1_000_000;
  localparam int HOLD_LEN = 300;
  localparam int SEG_LEN  = 160;
  localparam int SEGMENTS = 12;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  typedef enum int {PROF_RESET, PROF_NEAR, PROF_EXTREME, PROF_WIDE} level_profile_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [REG_W-1:0]     cfg_wdata;
  int                   mismatches;
  int                   outstanding;
  int                   cycle_count = 0;
  int                   send_idle_pct = 0;
  int                   recv_idle_pct = 0;
  int                   hold_requests = 0;
  int                   hold_served = 0;
  int                   hold_left = 0;
  int                   levels[6];

  dhhm_in_if  in_ch();
  dhhm_out_if out_ch();

  dual_hysteresis_health_monitor u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  dhhm_health_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] vib,
                             input logic signed [SAMPLE_W-1:0] temp,
                             input logic [TIME_W-1:0] stamp);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid       <= 1'b1;
    in_ch.vib_sample  <= vib;
    in_ch.temp_sample <= temp;
    in_ch.sample_time <= stamp;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_level(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= REG_W'(val);
    if (idx <= REG_TEMP_HYST) levels[idx] = val;
    @(posedge clk);
  endtask

  task automatic load_levels(input int vw, input int vc, input int vh,
                             input int tw, input int tc, input int th);
    write_level(REG_VIB_WARN, vw);
    write_level(REG_VIB_CRIT, vc);
    write_level(REG_VIB_HYST, vh);
    write_level(REG_TEMP_WARN, tw);
    write_level(REG_TEMP_CRIT, tc);
    write_level(REG_TEMP_HYST, th);
    write_level($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, $urandom_range(32767));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic int choose_level(level_profile_t prof, int reset_val, int cap);
    case (prof)
      PROF_RESET: return reset_val;
      PROF_NEAR:  return $urandom_range(cap);
      PROF_EXTREME: begin
        case ($urandom_range(3))
          0:       return 0;
          1:       return 1;
          2:       return 16384;
          default: return 32767;
        endcase
      end
      default: return $urandom_range(32767);
    endcase
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample(int warn, int crit, int hyst);
    int r, lo, hi, v;
    r = $urandom_range(99);
    if (r < 15) return SAMPLE_W'($urandom);
    if (r < 35) begin
      case ($urandom_range(7))
        0:       v = warn;
        1:       v = warn - 1;
        2:       v = warn - hyst;
        3:       v = warn - hyst - 1;
        4:       v = crit;
        5:       v = crit - 1;
        6:       v = 0;
        default: v = -1;
      endcase
      return SAMPLE_W'(v);
    end
    lo = warn - hyst - 16;
    hi = ((crit > warn) ? crit : warn) + 16;
    if (lo < -32768) lo = -32768;
    if (hi > 32767) hi = 32767;
    v = lo + int'($urandom_range(hi - lo));
    return SAMPLE_W'(v);
  endfunction

  initial begin
    level_profile_t prof;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.vib_sample  = '0;
    in_ch.temp_sample = '0;
    in_ch.sample_time = '0;
    levels = '{int'(RST_VIB_WARN), int'(RST_VIB_CRIT), int'(RST_VIB_HYST),
               int'(RST_TEMP_WARN), int'(RST_TEMP_CRIT), int'(RST_TEMP_HYST)};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 33;
    recv_idle_pct = 88;

    send_sample(16'sd0, 16'sd0, '0);
    send_sample(16'sd32767, 16'sd32767, '1);
    send_sample(-16'sd32768, -16'sd32768, 48'h5555_5555_5555);
    send_sample(16'sd256, 16'sd960, 48'hAAAA_AAAA_AAAA);
    send_sample(16'sd230, 16'sd928, TIME_W'({$urandom, $urandom}));
    send_sample(16'sd229, 16'sd927, TIME_W'({$urandom, $urandom}));
    send_sample(16'sd511, 16'sd1279, TIME_W'({$urandom, $urandom}));
    send_sample(16'sd512, 16'sd1280, TIME_W'({$urandom, $urandom}));
    send_sample(16'sd1, 16'sd1, TIME_W'({$urandom, $urandom}));
    send_sample(-16'sd1, -16'sd1, TIME_W'({$urandom, $urandom}));
    settle();

    load_levels(0, 0, 32767, 0, 0, 32767);
    send_sample(16'sd0, 16'sd0, TIME_W'({$urandom, $urandom}));
    send_sample(-16'sd100, -16'sd100, TIME_W'({$urandom, $urandom}));
    send_sample(-16'sd32767, -16'sd32767, TIME_W'({$urandom, $urandom}));
    send_sample(-16'sd32768, -16'sd32768, TIME_W'({$urandom, $urandom}));
    send_sample(-16'sd1, 16'sd5, TIME_W'({$urandom, $urandom}));
    settle();

    load_levels(32767, 1, 0, 32767, 1, 0);
    send_sample(16'sd32767, 16'sd32766, TIME_W'({$urandom, $urandom}));
    send_sample(16'sd32766, 16'sd32767, TIME_W'({$urandom, $urandom}));
    send_sample(16'sd2, 16'sd0, TIME_W'({$urandom, $urandom}));
    send_sample(16'sd1, 16'sd1, TIME_W'({$urandom, $urandom}));
    send_sample(16'sd0, 16'sd32767, TIME_W'({$urandom, $urandom}));
    settle();

    load_levels(100, 200, 0, 100, 200, 0);
    send_sample(16'sd100, 16'sd99, TIME_W'({$urandom, $urandom}));
    send_sample(16'sd99, 16'sd100, TIME_W'({$urandom, $urandom}));
    send_sample(16'sd100, 16'sd100, TIME_W'({$urandom, $urandom}));
    settle();

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg < 4) begin
        send_idle_pct = 33;
        recv_idle_pct = 88;
      end else if (seg < 8) begin
        send_idle_pct = 88;
        recv_idle_pct = 33;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      prof = level_profile_t'(seg % 4);
      load_levels(choose_level(prof, int'(RST_VIB_WARN), 1500),
                  choose_level(prof, int'(RST_VIB_CRIT), 2000),
                  choose_level(prof, int'(RST_VIB_HYST), 200),
                  choose_level(prof, int'(RST_TEMP_WARN), 1500),
                  choose_level(prof, int'(RST_TEMP_CRIT), 2000),
                  choose_level(prof, int'(RST_TEMP_HYST), 200));
      if (seg == 2 || seg == 9) hold_requests <= hold_requests + 1;
      repeat (SEG_LEN) begin
        send_sample(pick_sample(levels[REG_VIB_WARN], levels[REG_VIB_CRIT],
                                levels[REG_VIB_HYST]),
                    pick_sample(levels[REG_TEMP_WARN], levels[REG_TEMP_CRIT],
                                levels[REG_TEMP_HYST]),
                    TIME_W'({$urandom, $urandom}));
      end
      settle();
    end

    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
